// ===== rtl/core/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime test core.
`default_nettype none

package tdpt_pkg;

  // Width of the number port, fixed by the interface
  localparam int unsigned NUM_W = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the number, divisor = 2, square = 4
    logic div_start;  // start a remainder of number by divisor
    logic step;       // advance to the next candidate divisor
  } tdpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic trivial;    // negative, zero or one
    logic sq_gt;      // divisor squared exceeds the number
    logic div_done;   // remainder ready this cycle
    logic rem_zero;   // remainder is zero
  } tdpt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/trial_division_prime_test_core.sv =====
// Top level of the trial-division prime test core.
//
// Usage: drive number_i and raise start_i while busy_o is low; the word is
// taken at that clock edge and busy_o rises. The low WIDTH bits of number_i
// are tested (zero-extended when WIDTH exceeds 32); bit WIDTH-1 is the sign.
// When the search ends, done_o is high for exactly one cycle with is_prime_o
// valid in that cycle, and busy_o is already low, so the next word can be
// started in that same cycle.
// Negative, zero or one are answered from ST_TEST without a division.
// Otherwise each candidate divisor costs one pass through ST_TEST and ST_DIV,
// with the bit-serial remainder unit running while in ST_DIV;
// a prime near 2^31 at WIDTH = 32 tries about 46340 divisors.
// One word is in flight at a time.
// Reset: rst_ni clears the controller to idle with no result pending.
// The receiver cannot stall: the result must be taken in its strobe cycle.
`default_nettype none

module trial_division_prime_test_core #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tdpt_pkg::NUM_W-1:0]  number_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic                             is_prime_o
);

  import tdpt_pkg::*;

  tdpt_cmd_t  cmd;
  tdpt_stat_t stat;

  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  tdpt_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (number_i),
    .cmd_i    (cmd),
    .stat_o   (stat)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tdpt_div.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module tdpt_div #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic      [WIDTH-1:0] rem_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] shf_q;
  logic [WIDTH-1:0] dvs_q;
  logic [WIDTH:0]   trial;

  always_comb begin
    trial = {rem_q, shf_q[WIDTH-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = WIDTH'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      shf_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= {shf_q[WIDTH-2:0], 1'b0};
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/tdpt_datapath.sv =====
// Datapath: number, candidate divisor, running square and the remainder unit.
`default_nettype none

module tdpt_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [tdpt_pkg::NUM_W-1:0]     number_i,
  input  wire tdpt_pkg::tdpt_cmd_t            cmd_i,
  output tdpt_pkg::tdpt_stat_t                stat_o
);

  import tdpt_pkg::*;

  logic [WIDTH-1:0] num_ext;
  logic [WIDTH-1:0] v_q;
  logic [WIDTH-1:0] d_q;
  logic [WIDTH:0]   sq_q;   // d_q squared, kept by adding 2d+1 per step
  logic [WIDTH-1:0] rem;
  logic             div_done;

  // wider operands see the number zero-extended, narrower ones its low bits
  if (WIDTH > NUM_W) begin : g_ext
    assign num_ext = {{(WIDTH - NUM_W){1'b0}}, number_i};
  end else begin : g_trunc
    assign num_ext = number_i[WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= num_ext;
      d_q  <= WIDTH'(2);
      sq_q <= (WIDTH + 1)'(4);
    end else if (cmd_i.step) begin
      d_q  <= d_q + WIDTH'(1);
      sq_q <= sq_q + {d_q, 1'b1};
    end
  end

  tdpt_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (v_q),
    .divisor_i  (d_q),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  always_comb begin
    stat_o.trivial  = v_q[WIDTH-1] || (v_q < WIDTH'(2));
    stat_o.sq_gt    = sq_q > {1'b0, v_q};
    stat_o.div_done = div_done;
    stat_o.rem_zero = (rem == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/core/tdpt_ctrl.sv =====
// Controller: sequences the divisor search and drives the result strobe.
`default_nettype none

module tdpt_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire tdpt_pkg::tdpt_stat_t  stat_i,
  output tdpt_pkg::tdpt_cmd_t        cmd_o,
  output logic                       busy_o,
  output logic                       done_o,
  output logic                       is_prime_o
);

  import tdpt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   prime_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load      = start_i;
      ST_TEST: cmd_o.div_start = !stat_i.trivial && !stat_i.sq_gt;
      ST_DIV:  cmd_o.step      = stat_i.div_done && !stat_i.rem_zero;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_TEST;
        end
        ST_TEST: begin
          priority if (stat_i.trivial) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            prime_q <= 1'b0;
          end else if (stat_i.sq_gt) begin
            // no divisor up to the square root: prime
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            prime_q <= 1'b1;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (stat_i.div_done) begin
            if (stat_i.rem_zero) begin
              state_q <= ST_IDLE;
              done_q  <= 1'b1;
              prime_q <= 1'b0;
            end else begin
              state_q <= ST_TEST;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

endmodule

`default_nettype wire

// ===== rtl/core/tdpt_checker.sv =====
// Port-level assertions for the prime test core, bound to the top level.
`default_nettype none

module tdpt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic [tdpt_pkg::NUM_W-1:0]  number_i,
  input wire logic                        busy_o,
  input wire logic                        done_o,
  input wire logic                        is_prime_o
);

  // an accepted word makes the core busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("core not busy after start");

  // the result strobe comes with the core already idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // one word in flight: strobes never come back to back
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // zero and one are answered quickly, as not prime
  a_trivial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (number_i == 32'd0 || number_i == 32'd1)
      |-> ##2 (done_o && !is_prime_o))
    else $error("zero or one not answered as not prime");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .number_i   (number_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .is_prime_o (is_prime_o)
);

`default_nettype wire
